### rtl/kps_pkg.sv
// Shared types and constants for the k-permutation stepper.
// Used by kps_front, kps_queue, kps_back and the top level; depends on nothing.
`default_nettype none

package kps_pkg;

    localparam int DEF_MAX_ELEMS   = 16;
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_W       = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int INDEX_W     = 4;
    localparam int OP_W        = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ELEM_COUNT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PERM_LENGTH = CFG_INDEX_W'(1);

    localparam logic [CFG_W-1:0] ELEM_COUNT_RESET  = CFG_W'(16);
    localparam logic [CFG_W-1:0] PERM_LENGTH_RESET = CFG_W'(0);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_ADVANCE  = 2'd1,
        OP_OVERFLOW = 2'd2
    } kps_op_t;

    typedef struct packed {
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] k;
        logic             clear;
    } kps_cfg_t;

endpackage

`default_nettype wire

### rtl/k_permutation_stepper_unit.sv
// Top level of the k-permutation stepper: front, command queue and back part.
// Depends on kps_pkg, kps_front, kps_queue and kps_back.
`default_nettype none

// A command is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full, so the front keeps taking commands while the back
// part works. Results leave one per cycle on result_valid and cannot be held off.
// A load is written into the element memory as it leaves the queue. An advance leaves
// the queue, seeds the countdowns on a fresh start, then walks positions from k-1
// downward, rotating the tail at each position i whose countdown runs out, and closes
// with a swap at the first position whose countdown stays above zero, if any; it then
// streams the k results out of the single-read-port element memory. A k beyond n gives
// its single result in the cycle after it leaves the queue. Configuration writes are
// taken in every cycle.
module k_permutation_stepper_unit #(
    parameter int MAX_ELEMS   = kps_pkg::DEF_MAX_ELEMS,
    parameter int VALUE_WIDTH = kps_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            func,
    input  wire logic [kps_pkg::INDEX_W-1:0]     index,
    input  wire logic [VALUE_WIDTH-1:0]          value,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kps_pkg::CFG_W-1:0]       cfg_data,
    output logic                                 result_valid,
    output logic [kps_pkg::INDEX_W-1:0]          position,
    output logic [VALUE_WIDTH-1:0]               elem_value,
    output logic                                 more,
    output logic                                 last
);

    localparam int QW = kps_pkg::OP_W + kps_pkg::INDEX_W + VALUE_WIDTH;

    logic              push;
    logic [QW-1:0]     push_data;
    logic              pop;
    logic [QW-1:0]     pop_data;
    logic              q_full;
    logic              q_empty;
    kps_pkg::kps_cfg_t cfg;

    assign busy = q_full;

    kps_front #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .index     (index),
        .value     (value),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kps_queue #(
        .DATA_W (QW),
        .DEPTH  (kps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    kps_back #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .position     (position),
        .elem_value   (elem_value),
        .more         (more),
        .last         (last)
    );

endmodule

`default_nettype wire

### rtl/kps_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on kps_pkg for the default depth.
`default_nettype none

module kps_queue #(
    parameter int DATA_W = 22,
    parameter int DEPTH  = kps_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] pop_data,
    output logic                   full,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/kps_front.sv
// Front part: holds the configuration registers, takes commands and classifies them.
// Depends on kps_pkg for codes, widths and the configuration struct.
`default_nettype none

module kps_front #(
    parameter int MAX_ELEMS   = kps_pkg::DEF_MAX_ELEMS,
    parameter int VALUE_WIDTH = kps_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  func,
    input  wire logic [kps_pkg::INDEX_W-1:0]           index,
    input  wire logic [VALUE_WIDTH-1:0]                value,
    input  wire logic                                  q_full,
    output logic                                       push,
    output logic [kps_pkg::OP_W+kps_pkg::INDEX_W+VALUE_WIDTH-1:0] push_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [kps_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [kps_pkg::CFG_W-1:0]             cfg_data,
    output kps_pkg::kps_cfg_t                          cfg
);

    localparam int MW = $clog2(MAX_ELEMS + 1);
    localparam int LW = ((MW > kps_pkg::CFG_W) ? MW : kps_pkg::CFG_W) + 1;

    logic [kps_pkg::CFG_W-1:0] elem_count_reg;
    logic [kps_pkg::CFG_W-1:0] perm_length_reg;
    logic [kps_pkg::CFG_W-1:0] n_eff;
    logic [kps_pkg::CFG_W-1:0] k_eff;
    logic                      cfg_write;
    kps_pkg::kps_op_t          op;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (elem_count_reg == '0)
        begin
            n_eff = kps_pkg::CFG_W'(1);
        end
        else if (LW'(elem_count_reg) > LW'(MAX_ELEMS))
        begin
            n_eff = kps_pkg::CFG_W'(MAX_ELEMS);
        end
        else
        begin
            n_eff = elem_count_reg;
        end
        k_eff = (perm_length_reg == '0) ? n_eff : perm_length_reg;
    end

    always_comb
    begin
        if (!func)
        begin
            op = kps_pkg::OP_LOAD;
        end
        else if (k_eff > n_eff)
        begin
            op = kps_pkg::OP_OVERFLOW;
        end
        else
        begin
            op = kps_pkg::OP_ADVANCE;
        end
    end

    assign push      = start && !q_full;
    assign push_data = {op, index, value};

    assign cfg.n     = n_eff;
    assign cfg.k     = k_eff;
    assign cfg.clear = cfg_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg  <= kps_pkg::ELEM_COUNT_RESET;
            perm_length_reg <= kps_pkg::PERM_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kps_pkg::REG_ELEM_COUNT:  elem_count_reg  <= cfg_data;
                kps_pkg::REG_PERM_LENGTH: perm_length_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/kps_back.sv
// Back part: element and countdown memories and the sequencer that carries out commands.
// Depends on kps_pkg for codes, widths and the configuration struct.
`default_nettype none

module kps_back #(
    parameter int MAX_ELEMS   = kps_pkg::DEF_MAX_ELEMS,
    parameter int VALUE_WIDTH = kps_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire kps_pkg::kps_cfg_t                     cfg,
    input  wire logic                                  q_empty,
    input  wire logic [kps_pkg::OP_W+kps_pkg::INDEX_W+VALUE_WIDTH-1:0] q_data,
    output logic                                       pop,
    output logic                                       result_valid,
    output logic [kps_pkg::INDEX_W-1:0]                position,
    output logic [VALUE_WIDTH-1:0]                     elem_value,
    output logic                                       more,
    output logic                                       last
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int MW = $clog2(MAX_ELEMS + 1);
    localparam int LW = ((MW > kps_pkg::CFG_W) ? MW : kps_pkg::CFG_W) + 1;
    localparam int CW = kps_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_WALK_RD, S_WALK_EV, S_ROT_FIRST, S_ROT_MOVE, S_ROT_LAST,
        S_WALK_NEXT, S_SWAP_A, S_SWAP_B, S_SWAP_C, S_EMIT_RD, S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             i_reg, i_next;
    logic [AW-1:0]             p_reg, p_next;
    logic [AW-1:0]             j_reg, j_next;
    logic [VALUE_WIDTH-1:0]    hold_reg, hold_next;
    logic                      walk_more_reg, walk_more_next;
    logic                      started_reg, started_next;
    logic                      result_valid_reg, result_valid_next;
    logic [kps_pkg::INDEX_W-1:0] position_reg, position_next;
    logic [VALUE_WIDTH-1:0]    elem_value_reg, elem_value_next;
    logic                      more_reg, more_next;
    logic                      last_reg, last_next;

    logic [VALUE_WIDTH-1:0]    mem [MAX_ELEMS];
    logic [VALUE_WIDTH-1:0]    mem_rdata;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VALUE_WIDTH-1:0]    mem_wdata;
    logic [AW-1:0]             mem_raddr;

    logic [CW-1:0]             cnt [MAX_ELEMS];
    logic [CW-1:0]             cnt_rdata;
    logic                      cnt_we;
    logic [AW-1:0]             cnt_addr;
    logic [CW-1:0]             cnt_wdata;

    kps_pkg::kps_op_t          q_op;
    logic [kps_pkg::INDEX_W-1:0] q_index;
    logic [VALUE_WIDTH-1:0]    q_value;
    logic [CW-1:0]             c_dec;
    logic [CW-1:0]             n_minus_i;

    assign q_op    = kps_pkg::kps_op_t'(q_data[kps_pkg::OP_W+kps_pkg::INDEX_W+VALUE_WIDTH-1
                                               -: kps_pkg::OP_W]);
    assign q_index = q_data[kps_pkg::INDEX_W+VALUE_WIDTH-1 -: kps_pkg::INDEX_W];
    assign q_value = q_data[VALUE_WIDTH-1:0];

    assign c_dec     = cnt_rdata - CW'(1);
    assign n_minus_i = CW'(LW'(cfg.n) - LW'(i_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt[cnt_addr] <= cnt_wdata;
        end
        cnt_rdata <= cnt[cnt_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        p_next            = p_reg;
        j_next            = j_reg;
        hold_next         = hold_reg;
        walk_more_next    = walk_more_reg;
        started_next      = started_reg;
        result_valid_next = 1'b0;
        position_next     = position_reg;
        elem_value_next   = elem_value_reg;
        more_next         = more_reg;
        last_next         = last_reg;
        pop               = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = i_reg;
        mem_wdata         = mem_rdata;
        mem_raddr         = i_reg;
        cnt_we            = 1'b0;
        cnt_addr          = i_reg;
        cnt_wdata         = n_minus_i;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (q_op)
                        kps_pkg::OP_LOAD:
                        begin
                            if (LW'(q_index) < LW'(MAX_ELEMS))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(q_index);
                                mem_wdata = q_value;
                            end
                            started_next = 1'b0;
                        end
                        kps_pkg::OP_OVERFLOW:
                        begin
                            result_valid_next = 1'b1;
                            position_next     = '0;
                            elem_value_next   = '0;
                            more_next         = 1'b0;
                            last_next         = 1'b1;
                        end
                        kps_pkg::OP_ADVANCE:
                        begin
                            walk_more_next = 1'b0;
                            if (started_reg)
                            begin
                                i_next     = AW'(cfg.k - CW'(1));
                                state_next = S_WALK_RD;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                cnt_we = 1'b1;
                if (LW'(i_reg) + LW'(1) == LW'(cfg.k))
                begin
                    started_next = 1'b1;
                    i_next       = AW'(cfg.k - CW'(1));
                    state_next   = S_WALK_RD;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_EV;
            end
            S_WALK_EV:
            begin
                cnt_we = 1'b1;
                if (c_dec == '0)
                begin
                    state_next = S_ROT_FIRST;
                end
                else
                begin
                    cnt_wdata      = c_dec;
                    walk_more_next = 1'b1;
                    j_next         = (c_dec > cfg.n) ? AW'(MAX_ELEMS - 1)
                                                     : AW'(cfg.n - c_dec);
                    state_next     = S_SWAP_A;
                end
            end
            S_ROT_FIRST:
            begin
                hold_next = mem_rdata;
                if (LW'(i_reg) + LW'(1) < LW'(cfg.n))
                begin
                    mem_raddr  = i_reg + AW'(1);
                    p_next     = i_reg;
                    state_next = S_ROT_MOVE;
                end
                else
                begin
                    state_next = S_WALK_NEXT;
                end
            end
            S_ROT_MOVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg;
                mem_wdata = mem_rdata;
                if (LW'(p_reg) + LW'(2) < LW'(cfg.n))
                begin
                    mem_raddr = AW'(LW'(p_reg) + LW'(2));
                    p_next    = p_reg + AW'(1);
                end
                else
                begin
                    state_next = S_ROT_LAST;
                end
            end
            S_ROT_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(cfg.n - CW'(1));
                mem_wdata  = hold_reg;
                state_next = S_WALK_NEXT;
            end
            S_WALK_NEXT:
            begin
                if (i_reg == '0)
                begin
                    walk_more_next = 1'b0;
                    started_next   = 1'b0;
                    state_next     = S_EMIT_RD;
                end
                else
                begin
                    i_next     = i_reg - AW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_SWAP_A:
            begin
                hold_next  = mem_rdata;
                mem_raddr  = j_reg;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = mem_rdata;
                state_next = S_SWAP_C;
            end
            S_SWAP_C:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = hold_reg;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                mem_raddr  = '0;
                p_next     = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                result_valid_next = 1'b1;
                position_next     = kps_pkg::INDEX_W'(p_reg);
                elem_value_next   = mem_rdata;
                more_next         = walk_more_reg;
                last_next         = (LW'(p_reg) + LW'(1) == LW'(cfg.k));
                if (LW'(p_reg) + LW'(1) == LW'(cfg.k))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr = p_reg + AW'(1);
                    p_next    = p_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.clear)
        begin
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            p_reg            <= '0;
            j_reg            <= '0;
            hold_reg         <= '0;
            walk_more_reg    <= 1'b0;
            started_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            position_reg     <= '0;
            elem_value_reg   <= '0;
            more_reg         <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            p_reg            <= p_next;
            j_reg            <= j_next;
            hold_reg         <= hold_next;
            walk_more_reg    <= walk_more_next;
            started_reg      <= started_next;
            result_valid_reg <= result_valid_next;
            position_reg     <= position_next;
            elem_value_reg   <= elem_value_next;
            more_reg         <= more_next;
            last_reg         <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign elem_value   = elem_value_reg;
    assign more         = more_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
